// ----- rtl/core/gscar_pkg.sv -----
// ----------------------------------------------------------------------------
// gscar_pkg
// Shared widths, tag layout and sequencer states of the glyph slot cache.
// ----------------------------------------------------------------------------
`default_nettype none

package gscar_pkg;

   localparam int FONT_W     = 5;
   localparam int GLYPH_W    = 8;
   localparam int SLOT_OUT_W = 6;
   localparam int STAMP_W    = 16;
   localparam int GLYPHS     = 256;

   // one pool slot tag: glyph, font and age stamp
   typedef struct packed {
      logic [GLYPH_W-1:0] glyph;
      logic [FONT_W-1:0]  font;
      logic [STAMP_W-1:0] stamp;
   } tag_type;

   localparam int TAG_W = $bits(tag_type);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MAP_RD,
      ST_TAG_CHK,
      ST_SCAN,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/core/gscar_req_if.sv -----
// ----------------------------------------------------------------------------
// gscar_req_if
// Request channel: font index and glyph code with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface gscar_req_if
   import gscar_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic [FONT_W-1:0]  font_index;
   logic [GLYPH_W-1:0] glyph_code;

   modport source (output valid, output font_index, output glyph_code, input ready);
   modport sink   (input valid, input font_index, input glyph_code, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/gscar_rsp_if.sv -----
// ----------------------------------------------------------------------------
// gscar_rsp_if
// Response channel: hit flag and pool slot with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface gscar_rsp_if
   import gscar_pkg::*;
   ;
   logic                  valid;
   logic                  ready;
   logic                  hit;
   logic [SLOT_OUT_W-1:0] slot;

   modport source (output valid, output hit, output slot, input ready);
   modport sink   (input valid, input hit, input slot, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/gscar_ram.sv -----
// ----------------------------------------------------------------------------
// gscar_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gscar_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/gscar_stale_unit.sv -----
// ----------------------------------------------------------------------------
// gscar_stale_unit
// Age compare shared by every search step: stamp ahead of the counter, or
// lagging it by at least the pool size, marks the slot as reclaimable.
// ----------------------------------------------------------------------------
`default_nettype none

module gscar_stale_unit
   import gscar_pkg::*;
#(
   parameter int SLOTS = 64
) (
   input  logic [STAMP_W-1:0] counter,
   input  logic [STAMP_W-1:0] stamp,
   output logic               stale
);

   logic [STAMP_W-1:0] lag;

   always_comb begin
      lag   = counter - stamp;
      stale = (stamp > counter) || ({1'b0, lag} >= (STAMP_W+1)'(SLOTS));
   end

endmodule

`default_nettype wire

// ----- rtl/core/glyph_slot_cache_age_replace.sv -----
// ----------------------------------------------------------------------------
// glyph_slot_cache_age_replace
// Maps (font, glyph) to a pool slot; on a miss a round-robin pointer walks the
// pool until the age compare finds a reclaimable slot or the step limit is reached.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  req_ch  | in  | valid/ready        | font_index[4:0], glyph_code[7:0]
//  rsp_ch  | out | valid/ready        | hit, slot[5:0]
//
//  hit: rsp valid after the map read, then the tag read and compare
//  miss: map read and tag check, then k search steps (1 .. 2*SLOTS+2), one tag
//  read and one age compare per step through the shared compare unit
//  one item in flight; req ready again the cycle after the rsp is taken
//  after reset a clearing pass over all map and tag entries blocks req
//  a stalled rsp holds its payload; no new item is taken meanwhile
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_slot_cache_age_replace
   import gscar_pkg::*;
#(
   parameter int SLOTS = 64,
   parameter int FONTS = 32
) (
   input  logic        clock,
   input  logic        reset,
   gscar_req_if.sink   req_ch,
   gscar_rsp_if.source rsp_ch
);

   localparam int MAP_DEPTH = FONTS * GLYPHS;
   localparam int MAP_AW    = $clog2(MAP_DEPTH);
   localparam int TAG_AW    = $clog2(SLOTS);
   localparam int MAP_W     = 1 + TAG_AW;
   localparam int CLR_DEPTH = (MAP_DEPTH > SLOTS) ? MAP_DEPTH : SLOTS;
   localparam int CLR_W     = $clog2(CLR_DEPTH);
   localparam int LIMIT     = 2 * SLOTS + 2;
   localparam int STEP_W    = $clog2(LIMIT + 1);

   state_type state_ff, state_in;

   logic [CLR_W-1:0]   clr_ff, clr_in;
   logic [STAMP_W-1:0] ctr_ff, ctr_in;
   logic [TAG_AW-1:0]  ptr_ff, ptr_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [FONT_W-1:0]  font_ff, font_in;
   logic [GLYPH_W-1:0] glyph_ff, glyph_in;
   logic [MAP_AW-1:0]  map_addr_ff, map_addr_in;
   logic               ent_valid_ff, ent_valid_in;
   logic [TAG_AW-1:0]  ent_slot_ff, ent_slot_in;
   logic               hit_ff, hit_in;
   logic [TAG_AW-1:0]  slot_ff, slot_in;

   logic              map_wr_en, map_rd_en;
   logic [MAP_AW-1:0] map_wr_addr, map_rd_addr;
   logic [MAP_W-1:0]  map_wr_data, map_rd_data;
   logic              tag_wr_en, tag_rd_en;
   logic [TAG_AW-1:0] tag_wr_addr, tag_rd_addr;
   logic [TAG_W-1:0]  tag_wr_data, tag_rd_data;
   tag_type           tag_rd;

   logic              req_fire, is_hit, stale, scan_done, clr_last;
   logic [TAG_AW-1:0] ptr_next;
   logic [FONT_W-1:0] font_red;

   // font reduced modulo the font count, as a constant table
   logic [FONT_W-1:0] font_mod_lut [2**FONT_W];
   for (genvar i = 0; i < 2**FONT_W; i++) begin : g_font_mod
      assign font_mod_lut[i] = FONT_W'(i % FONTS);
   end

   gscar_ram #(.WIDTH(MAP_W), .DEPTH(MAP_DEPTH)) u_map_ram (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_en   (map_rd_en),
      .rd_addr (map_rd_addr),
      .rd_data (map_rd_data)
   );

   gscar_ram #(.WIDTH(TAG_W), .DEPTH(SLOTS)) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_wr_en),
      .wr_addr (tag_wr_addr),
      .wr_data (tag_wr_data),
      .rd_en   (tag_rd_en),
      .rd_addr (tag_rd_addr),
      .rd_data (tag_rd_data)
   );

   gscar_stale_unit #(.SLOTS(SLOTS)) u_stale (
      .counter (ctr_ff),
      .stamp   (tag_rd.stamp),
      .stale   (stale)
   );

   always_comb begin
      tag_rd    = tag_type'(tag_rd_data);
      font_red  = font_mod_lut[req_ch.font_index];
      req_fire  = req_ch.valid && req_ch.ready;
      clr_last  = (clr_ff == CLR_W'(CLR_DEPTH - 1));
      ptr_next  = (ptr_ff == TAG_AW'(SLOTS - 1)) ? '0 : ptr_ff + TAG_AW'(1);
      is_hit    = ent_valid_ff
                  && ({1'b0, ent_slot_ff} < (TAG_AW+1)'(SLOTS))
                  && (tag_rd.glyph == glyph_ff)
                  && (tag_rd.font == font_ff);
      scan_done = stale || (step_ff == STEP_W'(LIMIT));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) state_in = ST_MAP_RD;
         end
         ST_MAP_RD:  state_in = ST_TAG_CHK;
         ST_TAG_CHK: state_in = is_hit ? ST_RESP : ST_SCAN;
         ST_SCAN: begin
            if (scan_done) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ch.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      clr_in       = clr_ff;
      ctr_in       = ctr_ff;
      ptr_in       = ptr_ff;
      step_in      = step_ff;
      font_in      = font_ff;
      glyph_in     = glyph_ff;
      map_addr_in  = map_addr_ff;
      ent_valid_in = ent_valid_ff;
      ent_slot_in  = ent_slot_ff;
      hit_in       = hit_ff;
      slot_in      = slot_ff;
      map_wr_en    = 1'b0;
      map_wr_addr  = map_addr_ff;
      map_wr_data  = {1'b1, ptr_ff};
      map_rd_en    = 1'b0;
      map_rd_addr  = MAP_AW'({font_red, req_ch.glyph_code});
      tag_wr_en    = 1'b0;
      tag_wr_addr  = ptr_ff;
      tag_wr_data  = {glyph_ff, font_ff, ctr_ff};
      tag_rd_en    = 1'b0;
      tag_rd_addr  = ptr_next;
      req_ch.ready = 1'b0;
      rsp_ch.valid = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in      = clr_ff + CLR_W'(1);
            map_wr_en   = ({1'b0, clr_ff} < (CLR_W+1)'(MAP_DEPTH));
            map_wr_addr = clr_ff[MAP_AW-1:0];
            map_wr_data = '0;
            tag_wr_en   = ({1'b0, clr_ff} < (CLR_W+1)'(SLOTS));
            tag_wr_addr = clr_ff[TAG_AW-1:0];
            tag_wr_data = '0;
         end
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            map_rd_en    = req_fire;
            if (req_fire) begin
               font_in     = font_red;
               glyph_in    = req_ch.glyph_code;
               map_addr_in = map_rd_addr;
            end
         end
         ST_MAP_RD: begin
            ent_valid_in = map_rd_data[MAP_W-1];
            ent_slot_in  = map_rd_data[TAG_AW-1:0];
            tag_rd_en    = 1'b1;
            tag_rd_addr  = map_rd_data[TAG_AW-1:0];
         end
         ST_TAG_CHK: begin
            if (is_hit) begin
               // refresh the stamp, counter stays
               tag_wr_en   = 1'b1;
               tag_wr_addr = ent_slot_ff;
               hit_in      = 1'b1;
               slot_in     = ent_slot_ff;
            end else begin
               ptr_in    = ptr_next;
               ctr_in    = ctr_ff + STAMP_W'(1);
               step_in   = STEP_W'(1);
               tag_rd_en = 1'b1;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               tag_wr_en = 1'b1;
               map_wr_en = 1'b1;
               hit_in    = 1'b0;
               slot_in   = ptr_ff;
            end else begin
               // the next slot is read while this one is compared
               ptr_in    = ptr_next;
               ctr_in    = ctr_ff + STAMP_W'(1);
               step_in   = step_ff + STEP_W'(1);
               tag_rd_en = 1'b1;
            end
         end
         ST_RESP: begin
            rsp_ch.valid = 1'b1;
         end
         default: begin
         end
      endcase
      rsp_ch.hit  = hit_ff;
      rsp_ch.slot = SLOT_OUT_W'(slot_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         ctr_ff   <= '0;
         ptr_ff   <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         ctr_ff   <= ctr_in;
         ptr_ff   <= ptr_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      font_ff      <= font_in;
      glyph_ff     <= glyph_in;
      map_addr_ff  <= map_addr_in;
      ent_valid_ff <= ent_valid_in;
      ent_slot_ff  <= ent_slot_in;
      hit_ff       <= hit_in;
      slot_ff      <= slot_in;
   end

endmodule

`default_nettype wire

// ----- rtl/core/gscar_checker.sv -----
// ----------------------------------------------------------------------------
// gscar_checker
// Port-level checks of the glyph slot cache, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gscar_checker
   import gscar_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  rsp_hit,
   input logic [SLOT_OUT_W-1:0] rsp_slot
);

   // a stalled rsp keeps its item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_slot))
      else $error("rsp item changed while stalled");

   // one item at a time: never ready for a request while a rsp waits
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("req ready while rsp pending");

   // accepted item needs at least the map and tag reads
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !rsp_valid)
      else $error("rsp or ready right after accept");

   // a taken rsp is not shown twice
   a_rsp_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid)
      else $error("rsp repeated");

   // clearing pass follows reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("channel active after reset");

endmodule

bind glyph_slot_cache_age_replace gscar_checker u_gscar_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_hit   (rsp_ch.hit),
   .rsp_slot  (rsp_ch.slot)
);

`default_nettype wire

// ----- test/gscar_slot_checker.sv -----
// ----------------------------------------------------------------------------
// gscar_slot_checker
// Watches the request and response channels of the glyph slot cache, keeps
// its own copy of the glyph map, pool tags, age counter and victim pointer,
// and compares every response with the slot it should name.
// ----------------------------------------------------------------------------
`default_nettype none

module gscar_slot_checker
   import gscar_pkg::*;
#(
   parameter int SLOTS = 64,
   parameter int FONTS = 32
) (
   input  logic  clock,
   input  logic  reset,
   gscar_req_if  req_ch,
   gscar_rsp_if  rsp_ch,
   output int    mismatches,
   output int    waiting,
   output int    hits,
   output int    misses,
   output int    longest_walk
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAP_DEPTH  = FONTS * GLYPHS;
   localparam int WALK_BOUND = 2 * SLOTS + 2;

   typedef struct packed {
      logic                  hit;
      logic [SLOT_OUT_W-1:0] slot;
   } answer_type;

   logic                  map_valid [MAP_DEPTH];
   logic [SLOT_OUT_W-1:0] map_slot  [MAP_DEPTH];
   tag_type               pool_tags [SLOTS];
   logic [STAMP_W-1:0]    age_now;
   int unsigned           victim;
   answer_type            slot_answers [$];

   // plain 32-bit difference, no wrap handling
   function automatic bit is_reclaimable(input logic [STAMP_W-1:0] stamp);
      return (stamp > age_now) || ((32'(age_now) - 32'(stamp)) >= SLOTS);
   endfunction

   function automatic answer_type resolve_glyph(input logic [FONT_W-1:0] font_in,
                                                input logic [GLYPH_W-1:0] glyph);
      int unsigned font;
      int unsigned idx;
      int unsigned steps;
      answer_type  ans;
      font = font_in % FONTS;
      idx  = font * GLYPHS + glyph;
      if (map_valid[idx] && pool_tags[map_slot[idx]].glyph == glyph
          && pool_tags[map_slot[idx]].font == FONT_W'(font)) begin
         pool_tags[map_slot[idx]].stamp = age_now;
         hits++;
         ans.hit  = 1'b1;
         ans.slot = map_slot[idx];
         return ans;
      end
      // victim search: pointer and counter move together, one slot per step
      steps = 0;
      do begin
         victim  = (victim == SLOTS - 1) ? 0 : victim + 1;
         age_now = age_now + 1'b1;
         steps++;
      end while (!is_reclaimable(pool_tags[victim].stamp) && steps < WALK_BOUND);
      pool_tags[victim] = '{glyph: glyph, font: FONT_W'(font), stamp: age_now};
      map_valid[idx]    = 1'b1;
      map_slot[idx]     = SLOT_OUT_W'(victim);
      misses++;
      if (steps > longest_walk) begin
         longest_walk = steps;
      end
      ans.hit  = 1'b0;
      ans.slot = SLOT_OUT_W'(victim);
      return ans;
   endfunction

   always @(posedge clock) begin
      answer_type got;
      answer_type want;
      if (reset) begin
         foreach (map_valid[i]) map_valid[i] = 1'b0;
         foreach (pool_tags[i]) pool_tags[i] = '0;
         age_now = '0;
         victim  = 0;
         slot_answers.delete();
         hits         = 0;
         misses       = 0;
         longest_walk = 0;
         mismatches <= 0;
         waiting    <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            slot_answers.push_back(resolve_glyph(req_ch.font_index, req_ch.glyph_code));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.hit  = rsp_ch.hit;
            got.slot = rsp_ch.slot;
            if (slot_answers.size() == 0) begin
               $display("%0t: response with nothing outstanding: hit=%0b slot=%0d",
                        $time, got.hit, got.slot);
               mismatches <= mismatches + 1;
            end else begin
               want = slot_answers.pop_front();
               if (got.hit !== want.hit || got.slot !== want.slot) begin
                  $display("%0t: response mismatch: expected hit=%0b slot=%0d, got hit=%0b slot=%0d",
                           $time, want.hit, want.slot, got.hit, got.slot);
                  mismatches <= mismatches + 1;
               end
            end
         end
         waiting <= slot_answers.size();
      end
   end

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives glyph requests into the slot cache with random gaps on both sides,
// a long response stall and a full drain, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
   import gscar_pkg::*;
   ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS        = 64;
   localparam int FONTS        = 32;
   localparam int RANDOM_ITEMS = 450;
   localparam int CALM_TAIL    = 50;
   localparam int HOT_DEPTH    = 80;
   localparam int LONG_HOLD    = 300;
   localparam int SETTLE       = 200;
   localparam int LIMIT        = 40000;

   logic clock = 1'b0;
   logic reset;
   int   mismatches;
   int   waiting;
   int   hits;
   int   misses;
   int   longest_walk;
   int   sent;
   bit   idling;
   bit   hold_request;
   logic [FONT_W+GLYPH_W-1:0] hot_pairs [$];

   gscar_req_if req_ch ();
   gscar_rsp_if rsp_ch ();

   glyph_slot_cache_age_replace #(
      .SLOTS (SLOTS),
      .FONTS (FONTS)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   gscar_slot_checker #(
      .SLOTS (SLOTS),
      .FONTS (FONTS)
   ) i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .mismatches   (mismatches),
      .waiting      (waiting),
      .hits         (hits),
      .misses       (misses),
      .longest_walk (longest_walk)
   );

   always #5 clock = ~clock;

   task automatic offer(input logic [FONT_W-1:0] font, input logic [GLYPH_W-1:0] glyph);
      req_ch.valid      <= 1'b1;
      req_ch.font_index <= font;
      req_ch.glyph_code <= glyph;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent++;
      if (idling && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   // mostly revisit recent glyphs so hits refresh stamps and lengthen searches
   task automatic send_random();
      logic [FONT_W+GLYPH_W-1:0] pair;
      if (hot_pairs.size() != 0 && $urandom_range(0, 99) < 60) begin
         pair = hot_pairs[$urandom_range(0, hot_pairs.size() - 1)];
      end else begin
         pair = (FONT_W+GLYPH_W)'($urandom);
         hot_pairs.push_back(pair);
         if (hot_pairs.size() > HOT_DEPTH) begin
            void'(hot_pairs.pop_front());
         end
      end
      offer(pair[FONT_W+GLYPH_W-1:GLYPH_W], pair[GLYPH_W-1:0]);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (waiting != 0) @(posedge clock);
   endtask

   // response side; the long hold is taken once
   initial begin
      bit held;
      held = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !held) begin
            held = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else if (idling && $urandom_range(0, 4) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles without any accepted item
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
         if (quiet >= LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      req_ch.valid      <= 1'b0;
      req_ch.font_index <= '0;
      req_ch.glyph_code <= '0;
      reset             <= 1'b1;
      idling       = 1'b1;
      hold_request = 1'b0;
      sent         = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // zero tags at reset must not hit: map starts invalid
      offer(5'd0, 8'h00);
      offer(5'd0, 8'h00);
      offer(5'd31, 8'hff);
      offer(5'd31, 8'hff);
      offer(5'd0, 8'hff);
      offer(5'd31, 8'h00);
      // same glyph in another font is a separate entry
      offer(5'd1, 8'h00);
      offer(5'd0, 8'h00);
      offer(5'd1, 8'h00);
      offer(5'd21, 8'haa);
      offer(5'd10, 8'h55);
      offer(5'd21, 8'haa);
      offer(5'd10, 8'h55);
      offer(5'd0, 8'hff);
      offer(5'd31, 8'hff);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         idling = (n < RANDOM_ITEMS - CALM_TAIL) && ((n / 60) % 3 != 2);
         if (n == 100) begin
            hold_request = 1'b1;
         end
         if (n == 200) begin
            drain();
         end
         send_random();
      end
      drain();
      repeat (SETTLE) @(posedge clock);

      $display("%0d glyph requests: %0d found resident, %0d placed in a reclaimed slot",
               sent, hits, misses);
      $display("longest victim search %0d steps, with a long response stall and a full drain",
               longest_walk);
      if (mismatches == 0 && waiting == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire
